>>> hw/rtl/gnp_pkg.sv
// shared widths, types and register codes for the gradient noise pixel block
package gnp_pkg;

    localparam int PIX_W      = 12;
    localparam int FRAC_W     = 16;
    localparam int QUO_W      = PIX_W + FRAC_W;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = QUO_W / DIV_STEP;
    localparam int PITCH_W    = 10;
    localparam int IDX_W      = 24;
    localparam int GRAD_W     = 16;
    localparam int GRAD_FRAC  = 14;
    localparam int GIDX_W     = 11;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int BYTE_W     = 8;

    // fixed point bookkeeping: dot products Q30, vertical blend Q46
    localparam int DOT_FRAC     = GRAD_FRAC + FRAC_W;
    localparam int W_FRAC       = DOT_FRAC + FRAC_W;
    localparam int OUT_SCALE_LG = 7;
    localparam int OUT_SHIFT    = W_FRAC - OUT_SCALE_LG;
    localparam int OUT_BIAS     = 128;

    localparam logic [CFG_W-1:0]   CELL_RESET  = 12'd64;
    localparam logic [PITCH_W-1:0] PITCH_RESET = 10'd8;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    typedef logic signed [GRAD_W-1:0] grad_comp_t;

    typedef struct packed {
        grad_comp_t gx;
        grad_comp_t gy;
    } grad_t;

    typedef struct packed {
        logic              en;
        logic [GIDX_W-1:0] idx;
        grad_t             g;
    } grad_wr_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CELL_WIDTH  = 2'd0,
        REG_CELL_HEIGHT = 2'd1,
        REG_GRID_PITCH  = 2'd2
    } cfg_reg_t;

endpackage

>>> hw/rtl/gnp_div.sv
// pipelined restoring divider: (num * 2^16) / den, two quotient bits per stage
module gnp_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [gnp_pkg::PIX_W-1:0]   num,
    input  logic [gnp_pkg::PIX_W-1:0]   den,
    output logic [gnp_pkg::QUO_W-1:0]   quo
);
    import gnp_pkg::*;

    logic [PIX_W-1:0] rem_reg  [DIV_STAGES];
    logic [QUO_W-1:0] qd_reg   [DIV_STAGES];
    logic [PIX_W-1:0] rem_next [DIV_STAGES];
    logic [QUO_W-1:0] qd_next  [DIV_STAGES];
    logic [PIX_W-1:0] rem_in   [DIV_STAGES];
    logic [QUO_W-1:0] qd_in    [DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_stage
            // stage input: fresh dividend or previous stage
            if (s == 0)
            begin : g_first
                assign rem_in[s] = '0;
                assign qd_in[s]  = {num, FRAC_W'(0)};
            end
            else
            begin : g_rest
                assign rem_in[s] = rem_reg[s-1];
                assign qd_in[s]  = qd_reg[s-1];
            end

            // shift, trial subtract, set quotient bit
            always_comb
            begin
                logic [PIX_W:0]   trial;
                logic [PIX_W-1:0] r;
                logic [QUO_W-1:0] q;
                r = rem_in[s];
                q = qd_in[s];
                for (int k = 0; k < DIV_STEP; k++)
                begin
                    trial = {r, q[QUO_W-1]};
                    q     = {q[QUO_W-2:0], 1'b0};
                    if (trial >= {1'b0, den})
                    begin
                        trial = trial - {1'b0, den};
                        q[0]  = 1'b1;
                    end
                    r = trial[PIX_W-1:0];
                end
                rem_next[s] = r;
                qd_next[s]  = q;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next[s];
                    qd_reg[s]  <= qd_next[s];
                end
            end
        end
    endgenerate

    assign quo = qd_reg[DIV_STAGES-1];

endmodule

>>> hw/rtl/gnp_ease.sv
// three stage ease curve 3p^2 - 2p^3 on a Q0.16 fraction
module gnp_ease (
    input  logic                         clk,
    input  logic                         en,
    input  logic [gnp_pkg::FRAC_W-1:0]   frac,
    output logic [gnp_pkg::FRAC_W-1:0]   ease,
    output logic [gnp_pkg::FRAC_W-1:0]   frac_dly
);
    import gnp_pkg::*;

    localparam int P2_W  = 2 * FRAC_W;
    localparam int P3_W  = 3 * FRAC_W;
    localparam int NUM_W = P3_W + 2;

    logic [FRAC_W-1:0] f1_reg, f2_reg, f3_reg;
    logic [P2_W-1:0]   p2_reg, p2b_reg;
    logic [P3_W-1:0]   p3_reg;
    logic [FRAC_W-1:0] s_reg;
    logic [NUM_W-1:0]  num;

    // p^2 * 3 * 2^16 - 2 * p^3, always below 2^48
    assign num = ({2'b0, p2b_reg, FRAC_W'(0)} + {1'b0, p2b_reg, (FRAC_W+1)'(0)})
               - {1'b0, p3_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg  <= frac;
            p2_reg  <= frac * frac;
            f2_reg  <= f1_reg;
            p2b_reg <= p2_reg;
            p3_reg  <= p2_reg * f1_reg;
            f3_reg  <= f2_reg;
            s_reg   <= num[P2_W +: FRAC_W];
        end
    end

    assign ease     = s_reg;
    assign frac_dly = f3_reg;

endmodule

>>> hw/rtl/gnp_fetch.sv
// corner index arithmetic and the gradient table, one copy per corner row
module gnp_fetch #(
    parameter int GRID_ENTRIES = 1025
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [gnp_pkg::PIX_W-1:0]    cx,
    input  logic [gnp_pkg::PIX_W-1:0]    cy,
    input  logic [gnp_pkg::PITCH_W-1:0]  pitch,
    input  gnp_pkg::grad_wr_t            wr,
    output gnp_pkg::grad_t               g00,
    output gnp_pkg::grad_t               g10,
    output gnp_pkg::grad_t               g01,
    output gnp_pkg::grad_t               g11
);
    import gnp_pkg::*;

    localparam int AW = $clog2(GRID_ENTRIES);
    localparam logic [IDX_W-1:0] DEPTH = IDX_W'(GRID_ENTRIES);

    logic [PIX_W-1:0]   cx_reg;
    logic [PITCH_W-1:0] pitch_reg;
    logic [IDX_W-1:0]   prod_reg;
    logic [IDX_W-1:0]   i00_reg, i01_reg;
    logic [IDX_W-1:0]   i10, i11, wr_idx;
    logic               wr_ok;
    logic [3:0]         ok_reg;
    grad_t              rd00_reg, rd10_reg, rd01_reg, rd11_reg;

    grad_t mem_top [GRID_ENTRIES];
    grad_t mem_bot [GRID_ENTRIES];

    // row offset, then flat indexes of the top and bottom corners
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg    <= cx;
            pitch_reg <= pitch;
            prod_reg  <= IDX_W'(cy) * IDX_W'(pitch);
            i00_reg   <= IDX_W'(cx_reg) + prod_reg;
            i01_reg   <= IDX_W'(cx_reg) + prod_reg + IDX_W'(pitch_reg);
        end
    end

    assign i10    = i00_reg + IDX_W'(1);
    assign i11    = i01_reg + IDX_W'(1);
    assign wr_idx = IDX_W'(wr.idx);
    assign wr_ok  = wr.en && (wr_idx < DEPTH);

    // table copies: both written, each read at two corners
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (wr_ok)
            begin
                mem_top[wr_idx[AW-1:0]] <= wr.g;
                mem_bot[wr_idx[AW-1:0]] <= wr.g;
            end
            rd00_reg <= mem_top[i00_reg[AW-1:0]];
            rd10_reg <= mem_top[i10[AW-1:0]];
            rd01_reg <= mem_bot[i01_reg[AW-1:0]];
            rd11_reg <= mem_bot[i11[AW-1:0]];
            ok_reg   <= {i11 < DEPTH, i01_reg < DEPTH, i10 < DEPTH, i00_reg < DEPTH};
        end
    end

    // corners off the table read as zero gradient
    assign g00 = ok_reg[0] ? rd00_reg : '0;
    assign g10 = ok_reg[1] ? rd10_reg : '0;
    assign g01 = ok_reg[2] ? rd01_reg : '0;
    assign g11 = ok_reg[3] ? rd11_reg : '0;

endmodule

>>> hw/rtl/gnp_blend.sv
// dot products, horizontal and vertical blends, scaling to a byte
module gnp_blend (
    input  logic                         clk,
    input  logic                         en,
    input  gnp_pkg::grad_t               g00,
    input  gnp_pkg::grad_t               g10,
    input  gnp_pkg::grad_t               g01,
    input  gnp_pkg::grad_t               g11,
    input  logic [gnp_pkg::FRAC_W-1:0]   fx,
    input  logic [gnp_pkg::FRAC_W-1:0]   fy,
    input  logic [gnp_pkg::FRAC_W-1:0]   sx,
    input  logic [gnp_pkg::FRAC_W-1:0]   sy,
    output logic [gnp_pkg::BYTE_W-1:0]   noise
);
    import gnp_pkg::*;

    localparam int OFS_W  = FRAC_W + 1;
    localparam int PR_W   = GRAD_W + OFS_W;
    localparam int D_W    = PR_W + 1;
    localparam int DF_W   = D_W + 1;
    localparam int LO_W   = FRAC_W + 1;
    localparam int PLO_W  = LO_W + FRAC_W;
    localparam int HPT_W  = DF_W - LO_W + FRAC_W + 1;
    localparam int T_W    = D_W + 2;
    localparam int ST_W   = D_W + FRAC_W + 4;
    localparam int DV_W   = T_W + 1;
    localparam int HPV_W  = DV_W - LO_W + FRAC_W + 1;
    localparam int SW_W   = T_W + FRAC_W + 4;
    localparam int Q_W    = SW_W - OUT_SHIFT;
    localparam int R_W    = Q_W + 1;
    localparam int SX_DLY = 3;
    localparam int SY_DLY = 6;

    logic signed [OFS_W-1:0] ox0, ox1, oy0, oy1;
    logic signed [PR_W-1:0]  p00x_reg, p00y_reg, p10x_reg, p10y_reg;
    logic signed [PR_W-1:0]  p01x_reg, p01y_reg, p11x_reg, p11y_reg;
    logic signed [D_W-1:0]   d00_reg, d10_reg, d01_reg, d11_reg;
    logic signed [D_W-1:0]   at_reg, ab_reg, at2_reg, ab2_reg;
    logic signed [DF_W-1:0]  dft_reg, dfb_reg;
    logic [PLO_W-1:0]        plot_reg, plob_reg, plov_reg;
    logic signed [HPT_W-1:0] phit_reg, phib_reg;
    logic signed [ST_W-1:0]  sum_t, sum_b;
    logic signed [T_W-1:0]   top_reg, bot_reg, top2_reg, top3_reg;
    logic signed [DV_W-1:0]  dv_reg;
    logic signed [HPV_W-1:0] phiv_reg;
    logic signed [SW_W-1:0]  w;
    logic signed [Q_W-1:0]   q_reg;
    logic signed [R_W-1:0]   r;
    logic [BYTE_W-1:0]       noise_reg;
    logic [FRAC_W-1:0]       sx_reg [SX_DLY];
    logic [FRAC_W-1:0]       sy_reg [SY_DLY];

    // corner offsets: f and f - 1.0
    assign ox0 = $signed({1'b0, fx});
    assign ox1 = $signed({1'b1, fx});
    assign oy0 = $signed({1'b0, fy});
    assign oy1 = $signed({1'b1, fy});

    // ease weights wait for their blend stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg[0] <= sx;
            sy_reg[0] <= sy;
            for (int i = 1; i < SX_DLY; i++)
            begin
                sx_reg[i] <= sx_reg[i-1];
            end
            for (int i = 1; i < SY_DLY; i++)
            begin
                sy_reg[i] <= sy_reg[i-1];
            end
        end
    end

    // products, then dot products, then differences
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00x_reg <= g00.gx * ox0;
            p00y_reg <= g00.gy * oy0;
            p10x_reg <= g10.gx * ox1;
            p10y_reg <= g10.gy * oy0;
            p01x_reg <= g01.gx * ox0;
            p01y_reg <= g01.gy * oy1;
            p11x_reg <= g11.gx * ox1;
            p11y_reg <= g11.gy * oy1;

            d00_reg <= D_W'(p00x_reg) + D_W'(p00y_reg);
            d10_reg <= D_W'(p10x_reg) + D_W'(p10y_reg);
            d01_reg <= D_W'(p01x_reg) + D_W'(p01y_reg);
            d11_reg <= D_W'(p11x_reg) + D_W'(p11y_reg);

            at_reg  <= d00_reg;
            ab_reg  <= d01_reg;
            dft_reg <= DF_W'(d10_reg) - DF_W'(d00_reg);
            dfb_reg <= DF_W'(d11_reg) - DF_W'(d01_reg);
        end
    end

    // horizontal blend: difference times sx split in low and high halves
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plot_reg <= dft_reg[LO_W-1:0] * sx_reg[SX_DLY-1];
            plob_reg <= dfb_reg[LO_W-1:0] * sx_reg[SX_DLY-1];
            phit_reg <= $signed(dft_reg[DF_W-1:LO_W]) * $signed({1'b0, sx_reg[SX_DLY-1]});
            phib_reg <= $signed(dfb_reg[DF_W-1:LO_W]) * $signed({1'b0, sx_reg[SX_DLY-1]});
            at2_reg  <= at_reg;
            ab2_reg  <= ab_reg;
        end
    end

    assign sum_t = (ST_W'(at2_reg) <<< FRAC_W) + (ST_W'(phit_reg) <<< LO_W)
                 + ST_W'($signed({1'b0, plot_reg}));
    assign sum_b = (ST_W'(ab2_reg) <<< FRAC_W) + (ST_W'(phib_reg) <<< LO_W)
                 + ST_W'($signed({1'b0, plob_reg}));

    // floored rows, then vertical difference and its split product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            top_reg  <= sum_t[FRAC_W +: T_W];
            bot_reg  <= sum_b[FRAC_W +: T_W];
            dv_reg   <= DV_W'(bot_reg) - DV_W'(top_reg);
            top2_reg <= top_reg;
            plov_reg <= dv_reg[LO_W-1:0] * sy_reg[SY_DLY-1];
            phiv_reg <= $signed(dv_reg[DV_W-1:LO_W]) * $signed({1'b0, sy_reg[SY_DLY-1]});
            top3_reg <= top2_reg;
        end
    end

    // exact Q46 value, floor to the byte scale
    assign w = (SW_W'(top3_reg) <<< FRAC_W) + (SW_W'(phiv_reg) <<< LO_W)
             + SW_W'($signed({1'b0, plov_reg}));

    assign r = R_W'(q_reg) + R_W'(OUT_BIAS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= w[SW_W-1:OUT_SHIFT];
            if (r < 0)
            begin
                noise_reg <= '0;
            end
            else if (r > R_W'(255))
            begin
                noise_reg <= '1;
            end
            else
            begin
                noise_reg <= r[BYTE_W-1:0];
            end
        end
    end

    assign noise = noise_reg;

endmodule

>>> hw/rtl/gradient_noise_2d_pixel_top.sv
// top level of the 2d gradient noise pixel generator
//
// Each accepted word is either a gradient table write (action 0) or a noise
// pixel request (action 1); one word is taken every clock cycle while the
// output register is empty or being drained. A pixel request passes through
// 14 stages of a two-bit-per-stage divider that splits the coordinate into
// cell and Q0.16 fraction, 3 stages of corner index math and table read,
// and 9 stages of dot products, ease blends and byte scaling.
// Table writes pass down the same pipeline and land in the table at the read
// stage, so every pixel sees exactly the writes accepted before it. The table
// is held in two copies, each read at two corners per cycle. Entries read
// before they are written give an undefined value; corners past the end of
// the table count as zero gradients. Configuration may be changed only while
// the pipeline is empty.
module gradient_noise_2d_pixel_top #(
    parameter int GRID_ENTRIES = 1025
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gnp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gnp_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic                            action,
    input  logic [gnp_pkg::GIDX_W-1:0]      grad_index,
    input  logic signed [gnp_pkg::GRAD_W-1:0] grad_x,
    input  logic signed [gnp_pkg::GRAD_W-1:0] grad_y,
    input  logic [gnp_pkg::PIX_W-1:0]       pixel_x,
    input  logic [gnp_pkg::PIX_W-1:0]       pixel_y,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic [gnp_pkg::BYTE_W-1:0]      noise_byte
);
    import gnp_pkg::*;

    localparam int FETCH_LAT = 3;
    localparam int BLEND_LAT = 9;
    localparam int WR_STAGES = DIV_STAGES + FETCH_LAT - 1;
    localparam int TOTAL     = DIV_STAGES + FETCH_LAT + BLEND_LAT;

    logic [CFG_W-1:0]   cell_width_reg, cell_height_reg;
    logic [PITCH_W-1:0] grid_pitch_reg;
    logic [PIX_W-1:0]   cw_eff, ch_eff;
    logic               adv;
    logic [TOTAL-1:0]   pix_reg;
    logic [WR_STAGES-1:0] wr_vld_reg;
    logic [GIDX_W-1:0]  wr_idx_reg [WR_STAGES];
    grad_t              wr_g_reg   [WR_STAGES];
    grad_wr_t           wr;
    logic [QUO_W-1:0]   quo_x, quo_y;
    logic [FRAC_W-1:0]  sx, sy, fx, fy;
    grad_t              g00, g10, g01, g11;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg  <= CELL_RESET;
            cell_height_reg <= CELL_RESET;
            grid_pitch_reg  <= PITCH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CELL_WIDTH:  cell_width_reg  <= cfg_data;
                REG_CELL_HEIGHT: cell_height_reg <= cfg_data;
                REG_GRID_PITCH:  grid_pitch_reg  <= cfg_data[PITCH_W-1:0];
                default:         ;
            endcase
        end
    end

    // a zero cell size behaves as one
    assign cw_eff = (cell_width_reg == '0)  ? PIX_W'(1) : cell_width_reg;
    assign ch_eff = (cell_height_reg == '0) ? PIX_W'(1) : cell_height_reg;

    // whole pipeline moves when the output register is empty or being read
    assign adv       = !pix_reg[TOTAL-1] || res_ready;
    assign req_ready = adv;
    assign res_valid = pix_reg[TOTAL-1];

    // valid flags travel with the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg    <= '0;
            wr_vld_reg <= '0;
        end
        else if (adv)
        begin
            pix_reg    <= {pix_reg[TOTAL-2:0], req_valid && (action == ACT_PIXEL)};
            wr_vld_reg <= {wr_vld_reg[WR_STAGES-2:0], req_valid && (action == ACT_WRITE)};
        end
    end

    // table write payload delayed to the table read stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wr_idx_reg[0] <= grad_index;
            wr_g_reg[0]   <= '{gx: grad_x, gy: grad_y};
            for (int i = 1; i < WR_STAGES; i++)
            begin
                wr_idx_reg[i] <= wr_idx_reg[i-1];
                wr_g_reg[i]   <= wr_g_reg[i-1];
            end
        end
    end

    assign wr = '{en:  wr_vld_reg[WR_STAGES-1],
                  idx: wr_idx_reg[WR_STAGES-1],
                  g:   wr_g_reg[WR_STAGES-1]};

    gnp_div u_div_x (
        .clk (clk),
        .en  (adv),
        .num (pixel_x),
        .den (cw_eff),
        .quo (quo_x)
    );

    gnp_div u_div_y (
        .clk (clk),
        .en  (adv),
        .num (pixel_y),
        .den (ch_eff),
        .quo (quo_y)
    );

    gnp_ease u_ease_x (
        .clk      (clk),
        .en       (adv),
        .frac     (quo_x[FRAC_W-1:0]),
        .ease     (sx),
        .frac_dly (fx)
    );

    gnp_ease u_ease_y (
        .clk      (clk),
        .en       (adv),
        .frac     (quo_y[FRAC_W-1:0]),
        .ease     (sy),
        .frac_dly (fy)
    );

    gnp_fetch #(
        .GRID_ENTRIES (GRID_ENTRIES)
    ) u_fetch (
        .clk   (clk),
        .en    (adv),
        .cx    (quo_x[QUO_W-1:FRAC_W]),
        .cy    (quo_y[QUO_W-1:FRAC_W]),
        .pitch (grid_pitch_reg),
        .wr    (wr),
        .g00   (g00),
        .g10   (g10),
        .g01   (g01),
        .g11   (g11)
    );

    gnp_blend u_blend (
        .clk   (clk),
        .en    (adv),
        .g00   (g00),
        .g10   (g10),
        .g01   (g01),
        .g11   (g11),
        .fx    (fx),
        .fy    (fy),
        .sx    (sx),
        .sy    (sy),
        .noise (noise_byte)
    );

endmodule

>>> sim/gradient_noise_2d_pixel_top_test.sv
// testbench for the gradient noise pixel block: table load, pixels, random phases
`timescale 1ns / 100ps

module gradient_noise_2d_pixel_top_test;
    import gnp_pkg::*;

    localparam int TABLE_SIZE = 1025;

    typedef struct {
        logic                     act;
        logic [GIDX_W-1:0]        gidx;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [PIX_W-1:0]         px;
        logic [PIX_W-1:0]         py;
    } word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic req_valid = 1'b0;
    logic req_ready;
    logic action = 1'b0;
    logic [GIDX_W-1:0] grad_index = '0;
    logic signed [GRAD_W-1:0] grad_x = '0;
    logic signed [GRAD_W-1:0] grad_y = '0;
    logic [PIX_W-1:0] pixel_x = '0;
    logic [PIX_W-1:0] pixel_y = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    logic [BYTE_W-1:0] noise_byte;

    // predictor state
    logic signed [GRAD_W-1:0] grad_tab_x [0:TABLE_SIZE-1];
    logic signed [GRAD_W-1:0] grad_tab_y [0:TABLE_SIZE-1];
    int unsigned cell_w = 64;
    int unsigned cell_h = 64;
    int unsigned pitch = 8;

    // table entries with a write already queued
    bit filled [0:TABLE_SIZE-1];

    word_t pending_words [$];
    logic [BYTE_W-1:0] expected_bytes [$];
    int errors = 0;
    int pixels_checked = 0;
    int writes_sent = 0;
    int phases_run = 0;
    bit quiet = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;

    gradient_noise_2d_pixel_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .req_valid(req_valid), .req_ready(req_ready),
        .action(action), .grad_index(grad_index),
        .grad_x(grad_x), .grad_y(grad_y),
        .pixel_x(pixel_x), .pixel_y(pixel_y),
        .res_valid(res_valid), .res_ready(res_ready),
        .noise_byte(noise_byte)
    );

    always #5 clk = ~clk;

    // ease curve 3p^2 - 2p^3 in Q0.16
    function automatic longint ease_q16(longint p);
        longint p2;
        p2 = p * p;
        return (3 * p2 * 65536 - 2 * p2 * p) >>> 32;
    endfunction

    function automatic longint corner_dot(longint idx, longint ox, longint oy);
        if (idx >= TABLE_SIZE)
            return 0;
        return longint'(grad_tab_x[idx]) * ox + longint'(grad_tab_y[idx]) * oy;
    endfunction

    function automatic longint lerp_q30(longint a, longint b, longint s);
        return (a * 65536 + s * (b - a)) >>> 16;
    endfunction

    function automatic logic [BYTE_W-1:0] noise_of(logic [PIX_W-1:0] px,
                                                   logic [PIX_W-1:0] py);
        longint cw, ch, cx, cy, fx, fy, gx, gy, i00, i01;
        longint d00, d10, d01, d11, sx, sy, top, bot, w, r;
        cw = (cell_w == 0) ? 1 : cell_w;
        ch = (cell_h == 0) ? 1 : cell_h;
        cx = px / cw;
        cy = py / ch;
        fx = ((px % cw) << 16) / cw;
        fy = ((py % ch) << 16) / ch;
        gx = fx - 65536;
        gy = fy - 65536;
        i00 = cx + cy * pitch;
        i01 = cx + (cy + 1) * pitch;
        d00 = corner_dot(i00, fx, fy);
        d10 = corner_dot(i00 + 1, gx, fy);
        d01 = corner_dot(i01, fx, gy);
        d11 = corner_dot(i01 + 1, gx, gy);
        sx = ease_q16(fx);
        sy = ease_q16(fy);
        top = lerp_q30(d00, d10, sx);
        bot = lerp_q30(d01, d11, sx);
        w = top * 65536 + sy * (bot - top);
        r = (w >>> 39) + 128;
        if (r < 0)
            r = 0;
        else if (r > 255)
            r = 255;
        return r[BYTE_W-1:0];
    endfunction

    // flat table index of corner k (0 top left, 1 top right, 2 and 3 below)
    function automatic longint corner_index(int px, int py, int k);
        longint cw, ch;
        cw = (cell_w == 0) ? 1 : cell_w;
        ch = (cell_h == 0) ? 1 : cell_h;
        return px / cw + k % 2 + (py / ch + k / 2) * pitch;
    endfunction

    // true when a corner inside the table has no write queued yet
    function automatic bit corner_missing(int px, int py);
        longint idx;
        for (int k = 0; k < 4; k++)
        begin
            idx = corner_index(px, py, k);
            if (idx < TABLE_SIZE && !filled[idx])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // driver: predict on acceptance, then present the next word
    always @(posedge clk or negedge rst_n)
    begin
        word_t w;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                if (action == ACT_WRITE)
                begin
                    writes_sent++;
                    if (grad_index < TABLE_SIZE)
                    begin
                        grad_tab_x[grad_index] = grad_x;
                        grad_tab_y[grad_index] = grad_y;
                    end
                end
                else
                    expected_bytes.push_back(noise_of(pixel_x, pixel_y));
            end
            if (!req_valid || req_ready)
            begin
                if (send_gap == 0 && !quiet && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 4);
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    w = pending_words.pop_front();
                    req_valid <= 1'b1;
                    action <= w.act;
                    grad_index <= w.gidx;
                    grad_x <= w.gx;
                    grad_y <= w.gy;
                    pixel_x <= w.px;
                    pixel_y <= w.py;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor: check each result word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        logic [BYTE_W-1:0] want;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected noise_byte, expected none, actual %0d",
                             $time, noise_byte);
                    errors++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    pixels_checked++;
                    if (noise_byte !== want)
                    begin
                        $display("%0t: noise_byte mismatch, expected %0d, actual %0d",
                                 $time, want, noise_byte);
                        errors++;
                    end
                end
            end
            if (recv_gap == 0 && !quiet && $urandom_range(0, 9) == 0)
                recv_gap = $urandom_range(1, 4);
            if (recv_gap > 0)
            begin
                recv_gap--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    task automatic push_write(int idx, logic signed [GRAD_W-1:0] gx,
                              logic signed [GRAD_W-1:0] gy);
        word_t w;
        w.act = ACT_WRITE;
        w.gidx = GIDX_W'(idx);
        w.gx = gx;
        w.gy = gy;
        w.px = PIX_W'($urandom);
        w.py = PIX_W'($urandom);
        pending_words.push_back(w);
        if (idx >= 0 && idx < TABLE_SIZE)
            filled[idx] = 1'b1;
    endtask

    task automatic push_pixel(int px, int py);
        word_t w;
        longint idx;
        // corners inside the table get a gradient written ahead of the pixel
        for (int k = 0; k < 4; k++)
        begin
            idx = corner_index(px, py, k);
            if (idx < TABLE_SIZE && !filled[idx])
                push_write(int'(idx), GRAD_W'($urandom), GRAD_W'($urandom));
        end
        w.act = ACT_PIXEL;
        w.gidx = GIDX_W'($urandom);
        w.gx = GRAD_W'($urandom);
        w.gy = GRAD_W'($urandom);
        w.px = PIX_W'(px);
        w.py = PIX_W'(py);
        pending_words.push_back(w);
    endtask

    // wait until every word is in and every result is out, then let the pipe empty
    task automatic drain();
        while (pending_words.size() > 0 || req_valid || expected_bytes.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, int unsigned value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (r)
            REG_CELL_WIDTH:  cell_w = value & 12'hfff;
            REG_CELL_HEIGHT: cell_h = value & 12'hfff;
            default:         pitch = value & 10'h3ff;
        endcase
    endtask

    task automatic random_phase(int n);
        int px, py, tries;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                push_write($urandom_range(0, 2047), GRAD_W'($urandom), GRAD_W'($urandom));
            else
            begin
                // prefer pixels whose corners are already loaded
                tries = 0;
                px = $urandom_range(0, 4095);
                py = $urandom_range(0, 4095);
                while (corner_missing(px, py) && tries < 8)
                begin
                    px = $urandom_range(0, 4095);
                    py = $urandom_range(0, 4095);
                    tries++;
                end
                push_pixel(px, py);
            end
        end
        drain();
        phases_run++;
    endtask

    // stimulus
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load the low part of the table, other corners are loaded on demand
        for (int i = 0; i < 256; i++)
            push_write(i, GRAD_W'($urandom), GRAD_W'($urandom));
        drain();

        // directed: extreme gradients, ignored writes, extreme coordinates
        push_write(0, 16'sd16384, 16'sd16384);
        push_write(1, -16'sd16384, 16'sd16384);
        push_write(8, 16'sh7fff, -16'sh8000);
        push_write(9, -16'sh8000, 16'sh7fff);
        push_write(1024, -16'sd16384, -16'sd16384);
        push_write(1025, 16'sh7fff, 16'sh7fff);
        push_write(2047, -16'sh8000, -16'sh8000);
        push_pixel(0, 0);
        push_pixel(63, 63);
        push_pixel(32, 32);
        push_pixel(1, 62);
        push_pixel(4095, 4095);
        push_pixel(4095, 0);
        push_pixel(0, 4095);
        push_pixel(511, 511);
        push_pixel(64, 64);
        drain();

        // register sweeps, extremes included, zero size acting as one
        write_reg(REG_CELL_WIDTH, 1);
        write_reg(REG_CELL_HEIGHT, 1);
        write_reg(REG_GRID_PITCH, 1023);
        push_pixel(0, 0);
        push_pixel(4095, 4095);
        random_phase(60);

        write_reg(REG_CELL_WIDTH, 4095);
        write_reg(REG_CELL_HEIGHT, 4095);
        write_reg(REG_GRID_PITCH, 1);
        push_pixel(4094, 4094);
        random_phase(60);

        write_reg(REG_CELL_WIDTH, 0);
        write_reg(REG_CELL_HEIGHT, 0);
        write_reg(REG_GRID_PITCH, 0);
        random_phase(50);

        write_reg(REG_CELL_WIDTH, 7);
        write_reg(REG_CELL_HEIGHT, 300);
        write_reg(REG_GRID_PITCH, 600);
        random_phase(60);

        for (int k = 0; k < 2; k++)
        begin
            write_reg(REG_CELL_WIDTH, $urandom_range(1, 4095));
            write_reg(REG_CELL_HEIGHT, $urandom_range(1, 4095));
            write_reg(REG_GRID_PITCH, $urandom_range(1, 1023));
            random_phase(60);
        end

        write_reg(REG_CELL_WIDTH, 64);
        write_reg(REG_CELL_HEIGHT, 64);
        write_reg(REG_GRID_PITCH, 8);
        random_phase(50);

        // last stretch at full rate
        write_reg(REG_CELL_WIDTH, 37);
        write_reg(REG_CELL_HEIGHT, 19);
        write_reg(REG_GRID_PITCH, 200);
        quiet = 1'b1;
        random_phase(60);

        $display("covered %0d table writes and %0d checked pixels over %0d random phases",
                 writes_sent, pixels_checked, phases_run);
        $display("register sweeps hit cell sizes 0, 1, 4095 and pitches 0, 1, 1023");
        if (errors == 0)
            $display("gradient_noise_2d_pixel_top test passed");
        else
            $display("gradient_noise_2d_pixel_top test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("timeout waiting for results");
        $display("gradient_noise_2d_pixel_top test failed");
        $finish;
    end

endmodule
